[hdl/wnss_pkg.sv]
// ----------------------------------------------------------------------------
// wnss_pkg
// shared widths, constants and helpers for the weighted node score selector
// ----------------------------------------------------------------------------
package wnss_pkg;

	localparam int CAP_W   = 32;
	localparam int REP_W   = 16;
	localparam int PHASE_W = 15;
	localparam int LAT_W   = 16;
	localparam int IDX_W   = 8;
	localparam int SCORE_W = 25;

	localparam int MAX_CANDIDATES_DEF = 256;

	// phase in 1/64 degree
	localparam logic [PHASE_W-1:0] PHASE_FULL = 15'd23040;
	localparam logic [PHASE_W-1:0] PHASE_HALF = 15'd11520;

	localparam logic [CAP_W-1:0] CAP_LIMIT = 32'd1000;
	localparam logic signed [REP_W-1:0] REP_LIMIT = 16'sd25600;
	localparam logic [LAT_W-1:0] LAT_LIMIT = 16'd1600;

	// clamped field widths
	localparam int CAPC_W = 10;
	localparam int REPC_W = 15;

	// score weights, scaled so the sum is exact
	localparam logic [SCORE_W-1:0] W_CAP      = 25'd4608;
	localparam logic [SCORE_W-1:0] W_REP      = 25'd135;
	localparam logic [SCORE_W-1:0] W_PHASE    = 25'd300;
	localparam logic [SCORE_W-1:0] SCORE_BASE = 25'd3456000;

	// fold a raw phase into 0 .. just under 360 degrees
	function automatic logic [PHASE_W-1:0] phase_reduce(input logic [PHASE_W-1:0] p);
		logic [PHASE_W-1:0] r;
		if (p >= PHASE_FULL) begin
			r = p - PHASE_FULL;
		end else begin
			r = p;
		end
		return r;
	endfunction

endpackage

[hdl/weighted_node_score_select_top.sv]
// ----------------------------------------------------------------------------
// weighted_node_score_select_top
// scores a stream of candidate nodes and reports the index of the best one
// ----------------------------------------------------------------------------
//
// channel  | handshake               | payload
// ---------+-------------------------+---------------------------------------
// input    | in_valid / in_stall     | capacity, reputation, node_phase,
//          |                         | latency, last_candidate
// output   | out_valid / out_stall   | best_index
// config   | cfg_wr_en (no wait)     | cfg_wr_data -> own_phase
//
// one word per cycle while in_stall is low; a word is captured in the input
// stage, then scored and compared against the running best, and the result
// of a last word is loaded into the output register as that word leaves
// reset (arst_n low) clears the selection, own_phase and all valid flags
// in_stall rises only when a last word waits in the input stage while the
// output register still holds an untaken result; non-last words keep flowing
// ----------------------------------------------------------------------------
module weighted_node_score_select_top #(
	parameter int MAX_CANDIDATES = wnss_pkg::MAX_CANDIDATES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,

	// configuration
	input  logic                                 cfg_wr_en,
	input  logic [wnss_pkg::PHASE_W-1:0]         cfg_wr_data,

	// candidate words
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [wnss_pkg::CAP_W-1:0]           capacity,
	input  logic signed [wnss_pkg::REP_W-1:0]    reputation,
	input  logic [wnss_pkg::PHASE_W-1:0]         node_phase,
	input  logic [wnss_pkg::LAT_W-1:0]           latency,
	input  logic                                 last_candidate,

	// result words
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [wnss_pkg::IDX_W-1:0]           best_index
);

	// position of a scored candidate, and a counter that can hold the limit
	localparam int POS_W = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
	localparam int CNT_W = $clog2(MAX_CANDIDATES + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CANDIDATES);

	// local phase register
	logic [wnss_pkg::PHASE_W-1:0] own_phase_q;

	// input stage
	logic                                 valid_s1;
	logic [wnss_pkg::CAP_W-1:0]           capacity_s1;
	logic signed [wnss_pkg::REP_W-1:0]    reputation_s1;
	logic [wnss_pkg::PHASE_W-1:0]         node_phase_s1;
	logic [wnss_pkg::LAT_W-1:0]           latency_s1;
	logic                                 last_s1;

	// running selection
	logic [wnss_pkg::SCORE_W-1:0] best_score_q;
	logic                         have_best_q;
	logic [POS_W-1:0]             best_pos_q;
	logic [CNT_W-1:0]             item_cnt_q;

	// output register
	logic                         out_valid_q;
	logic [wnss_pkg::IDX_W-1:0]   best_index_q;

	logic consume;
	logic accept;

	// scoring path
	logic [wnss_pkg::CAPC_W-1:0]  cap_c;
	logic [wnss_pkg::REPC_W-1:0]  rep_c;
	logic [wnss_pkg::PHASE_W-1:0] phase_b;
	logic [wnss_pkg::PHASE_W-1:0] diff_raw;
	logic [wnss_pkg::PHASE_W-1:0] diff;
	logic [wnss_pkg::SCORE_W-1:0] cap_term;
	logic [wnss_pkg::SCORE_W-1:0] rep_term;
	logic [wnss_pkg::SCORE_W-1:0] phase_term;
	logic [wnss_pkg::SCORE_W-1:0] base_score;
	logic [wnss_pkg::SCORE_W-1:0] score;

	// selection update
	logic                         scorable;
	logic                         take_new;
	logic                         sel_have;
	logic [POS_W-1:0]             sel_pos;
	logic [POS_W+wnss_pkg::IDX_W-1:0] sel_pos_ext;

	// a last word can leave the input stage only if the output register is free
	assign consume  = valid_s1 && (!last_s1 || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !consume;
	assign accept   = in_valid && !in_stall;

	// ---- scoring ----
	always_comb begin
		// capacity clamp
		if (capacity_s1 >= wnss_pkg::CAP_LIMIT) begin
			cap_c = wnss_pkg::CAPC_W'(wnss_pkg::CAP_LIMIT);
		end else begin
			cap_c = capacity_s1[wnss_pkg::CAPC_W-1:0];
		end

		// reputation clamp to 0 .. 100
		if (reputation_s1 <= 16'sd0) begin
			rep_c = '0;
		end else if (reputation_s1 >= wnss_pkg::REP_LIMIT) begin
			rep_c = wnss_pkg::REPC_W'(wnss_pkg::REP_LIMIT);
		end else begin
			rep_c = reputation_s1[wnss_pkg::REPC_W-1:0];
		end

		// phase distance folded to at most 180 degrees
		phase_b = wnss_pkg::phase_reduce(node_phase_s1);
		if (own_phase_q > phase_b) begin
			diff_raw = own_phase_q - phase_b;
		end else begin
			diff_raw = phase_b - own_phase_q;
		end
		if (diff_raw > wnss_pkg::PHASE_HALF) begin
			diff = wnss_pkg::PHASE_FULL - diff_raw;
		end else begin
			diff = diff_raw;
		end

		cap_term   = wnss_pkg::SCORE_W'(cap_c) * wnss_pkg::W_CAP;
		rep_term   = wnss_pkg::SCORE_W'(rep_c) * wnss_pkg::W_REP;
		phase_term = wnss_pkg::SCORE_W'(diff) * wnss_pkg::W_PHASE;
		// never negative: phase_term is at most the base
		base_score = cap_term + rep_term + wnss_pkg::SCORE_BASE - phase_term;

		// double unless the latency is above 100 ms
		if (latency_s1 <= wnss_pkg::LAT_LIMIT) begin
			score = {base_score[wnss_pkg::SCORE_W-2:0], 1'b0};
		end else begin
			score = base_score;
		end
	end

	// ---- selection ----
	always_comb begin
		scorable    = item_cnt_q < CNT_MAX;
		take_new    = scorable && (!have_best_q || score > best_score_q);
		sel_have    = have_best_q || scorable;
		sel_pos     = take_new ? item_cnt_q[POS_W-1:0] : best_pos_q;
		sel_pos_ext = {{wnss_pkg::IDX_W{1'b0}}, sel_pos};
	end

	// ---- config ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_phase_q <= '0;
		end else if (cfg_wr_en) begin
			own_phase_q <= wnss_pkg::phase_reduce(cfg_wr_data);
		end
	end

	// ---- input stage ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			capacity_s1   <= capacity;
			reputation_s1 <= reputation;
			node_phase_s1 <= node_phase;
			latency_s1    <= latency;
			last_s1       <= last_candidate;
		end
	end

	// ---- running best ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_best_q <= 1'b0;
			best_pos_q  <= '0;
			item_cnt_q  <= '0;
		end else if (consume) begin
			if (last_s1) begin
				// selection done, start over
				have_best_q <= 1'b0;
				best_pos_q  <= '0;
				item_cnt_q  <= '0;
			end else begin
				have_best_q <= sel_have;
				best_pos_q  <= sel_pos;
				if (scorable) begin
					item_cnt_q <= item_cnt_q + CNT_W'(1);
				end
			end
		end
	end

	// score only matters while have_best_q is set
	always_ff @(posedge clk) begin
		if (consume && take_new) begin
			best_score_q <= score;
		end
	end

	// ---- output register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (consume && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && last_s1) begin
			best_index_q <= sel_have ? sel_pos_ext[wnss_pkg::IDX_W-1:0] : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign best_index = best_index_q;

endmodule

[hdl/wnss_checker.sv]
// ----------------------------------------------------------------------------
// wnss_checker
// port level checks for the weighted node score selector
// ----------------------------------------------------------------------------
module wnss_checker #(
	parameter int MAX_CANDIDATES = wnss_pkg::MAX_CANDIDATES_DEF
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              last_candidate,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [wnss_pkg::IDX_W-1:0]        best_index
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(best_index))
		else $error("result word changed while stalled");

	// input backpressure only comes from a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a pending result");

	// index stays inside the selection size
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (MAX_CANDIDATES > 256) || (32'(best_index) < MAX_CANDIDATES))
		else $error("best index beyond candidate limit");

	// a last word entering a free pipeline passes the input stage and then sets the result word
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last_candidate && !out_valid && !in_stall
			##1 !out_valid |=> out_valid)
		else $error("result word missing after last candidate");

endmodule

bind weighted_node_score_select_top wnss_checker #(
	.MAX_CANDIDATES(MAX_CANDIDATES)
) u_wnss_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.last_candidate (last_candidate),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.best_index     (best_index)
);

[tb/weighted_node_score_select_checker.sv]
// ----------------------------------------------------------------------------
// weighted_node_score_select_checker
// watches the candidate, result and own_phase ports, predicts best_index
// for every selection and compares it with what the block hands out
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module weighted_node_score_select_checker #(
	parameter int MAX_CANDIDATES = wnss_pkg::MAX_CANDIDATES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [wnss_pkg::PHASE_W-1:0]         cfg_wr_data,
	input  logic                                 in_valid,
	input  logic                                 in_stall,
	input  logic [wnss_pkg::CAP_W-1:0]           capacity,
	input  logic signed [wnss_pkg::REP_W-1:0]    reputation,
	input  logic [wnss_pkg::PHASE_W-1:0]         node_phase,
	input  logic [wnss_pkg::LAT_W-1:0]           latency,
	input  logic                                 last_candidate,
	input  logic                                 out_valid,
	input  logic                                 out_stall,
	input  logic [wnss_pkg::IDX_W-1:0]           best_index,
	output int                                   fail_count,
	output int                                   expected_left
);

	localparam logic [wnss_pkg::PHASE_W-1:0] FULL_TURN = 15'd23040;
	localparam logic [wnss_pkg::PHASE_W-1:0] HALF_TURN = 15'd11520;

	logic [wnss_pkg::PHASE_W-1:0] cur_own_phase = '0;
	logic [wnss_pkg::SCORE_W-1:0] lead_score    = '0;
	bit                           lead_valid    = 1'b0;
	int unsigned                  lead_pos      = 0;
	int unsigned                  seen_count    = 0;
	int                           fails         = 0;
	logic [wnss_pkg::IDX_W-1:0]   best_index_q[$];

	function automatic logic [wnss_pkg::PHASE_W-1:0] wrap_turn(
		input logic [wnss_pkg::PHASE_W-1:0] p
	);
		return (p >= FULL_TURN) ? p - FULL_TURN : p;
	endfunction

	// exact scaled score of one candidate against the current local phase
	function automatic logic [wnss_pkg::SCORE_W-1:0] node_score(
		input logic [wnss_pkg::CAP_W-1:0]        cap_in,
		input logic signed [wnss_pkg::REP_W-1:0] rep_in,
		input logic [wnss_pkg::PHASE_W-1:0]      ph_in,
		input logic [wnss_pkg::LAT_W-1:0]        lat_in
	);
		logic [9:0]                   cap_c;
		logic [14:0]                  rep_c;
		logic [wnss_pkg::PHASE_W-1:0] ph_r;
		logic [wnss_pkg::PHASE_W-1:0] phase_gap;
		logic [31:0]                  sum;
		cap_c = (cap_in >= 32'd1000) ? 10'd1000 : cap_in[9:0];
		if (rep_in <= 0) begin
			rep_c = '0;
		end else if (rep_in >= 16'sd25600) begin
			rep_c = 15'd25600;
		end else begin
			rep_c = rep_in[14:0];
		end
		ph_r = wrap_turn(ph_in);
		phase_gap = (cur_own_phase > ph_r) ? cur_own_phase - ph_r : ph_r - cur_own_phase;
		if (phase_gap > HALF_TURN) begin
			phase_gap = FULL_TURN - phase_gap;
		end
		sum = 32'd4608 * cap_c + 32'd135 * rep_c + 32'd3456000 - 32'd300 * phase_gap;
		if (lat_in <= 16'd1600) begin
			sum = sum << 1;
		end
		return sum[wnss_pkg::SCORE_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [wnss_pkg::SCORE_W-1:0] s;
		logic [wnss_pkg::IDX_W-1:0]   want;
		if (!arst_n) begin
			cur_own_phase = '0;
			lead_score    = '0;
			lead_valid    = 1'b0;
			lead_pos      = 0;
			seen_count    = 0;
			best_index_q.delete();
			expected_left <= 0;
			fail_count    <= fails;
		end else begin
			if (cfg_wr_en) begin
				cur_own_phase = wrap_turn(cfg_wr_data);
			end
			// a result leaves only after its last word has been taken
			if (out_valid && !out_stall) begin
				if (best_index_q.size() == 0) begin
					$error("best_index word %0d with no selection pending", best_index);
					fails++;
				end else begin
					want = best_index_q.pop_front();
					if (best_index !== want) begin
						$error("best_index mismatch: expected %0d, actual %0d", want, best_index);
						fails++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (seen_count < MAX_CANDIDATES) begin
					s = node_score(capacity, reputation, node_phase, latency);
					if (!lead_valid || s > lead_score) begin
						lead_score = s;
						lead_pos   = seen_count;
						lead_valid = 1'b1;
					end
					seen_count++;
				end
				if (last_candidate) begin
					best_index_q.push_back(lead_valid ? lead_pos[wnss_pkg::IDX_W-1:0] : '0);
					lead_score = '0;
					lead_valid = 1'b0;
					lead_pos   = 0;
					seen_count = 0;
				end
			end
			expected_left <= best_index_q.size();
			fail_count    <= fails;
		end
	end

endmodule

[tb/tb_weighted_node_score_select_top.sv]
// ----------------------------------------------------------------------------
// tb_weighted_node_score_select_top
// drives candidate selections and own_phase settings into the selector and
// gives the verdict; prediction and comparison live in the checker beside it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_weighted_node_score_select_top;

	typedef struct {
		logic [wnss_pkg::CAP_W-1:0]        cap;
		logic signed [wnss_pkg::REP_W-1:0] rep;
		logic [wnss_pkg::PHASE_W-1:0]      ph;
		logic [wnss_pkg::LAT_W-1:0]        lat;
	} cand_t;

	// idling patterns for sender and receiver
	typedef enum int {
		IDLE_SEND31_RECV45,
		IDLE_SEND45_RECV31,
		IDLE_NONE
	} idle_mode_t;

	logic                              clk            = 1'b0;
	logic                              arst_n         = 1'b0;
	logic                              cfg_wr_en      = 1'b0;
	logic [wnss_pkg::PHASE_W-1:0]      cfg_wr_data    = '0;
	logic                              in_valid       = 1'b0;
	logic                              in_stall;
	logic [wnss_pkg::CAP_W-1:0]        capacity       = '0;
	logic signed [wnss_pkg::REP_W-1:0] reputation     = '0;
	logic [wnss_pkg::PHASE_W-1:0]      node_phase     = '0;
	logic [wnss_pkg::LAT_W-1:0]        latency        = '0;
	logic                              last_candidate = 1'b0;
	logic                              out_valid;
	logic                              out_stall      = 1'b0;
	logic [wnss_pkg::IDX_W-1:0]        best_index;

	int         fail_count;
	int         expected_left;
	idle_mode_t idle_mode = IDLE_SEND31_RECV45;
	bit         hold_req  = 1'b0;
	int         hold_left = 0;
	int         words_sent  = 0;
	int         selections  = 0;
	int         phase_writes = 0;

	// 2 ns clock
	always #1 clk = ~clk;

	weighted_node_score_select_top i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.capacity       (capacity),
		.reputation     (reputation),
		.node_phase     (node_phase),
		.latency        (latency),
		.last_candidate (last_candidate),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.best_index     (best_index)
	);

	weighted_node_score_select_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.capacity       (capacity),
		.reputation     (reputation),
		.node_phase     (node_phase),
		.latency        (latency),
		.last_candidate (last_candidate),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.best_index     (best_index),
		.fail_count     (fail_count),
		.expected_left  (expected_left)
	);

	// result side: random stall per idle mode, or a long counted hold-off
	// when the sender asks for one so the pipeline backs up into in_stall
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = 80;
		end
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			case (idle_mode)
				IDLE_SEND31_RECV45: out_stall <= ($urandom_range(0, 99) < 45);
				IDLE_SEND45_RECV31: out_stall <= ($urandom_range(0, 99) < 31);
				default:            out_stall <= 1'b0;
			endcase
		end
	end

	function automatic bit sender_idles();
		case (idle_mode)
			IDLE_SEND31_RECV45: return $urandom_range(0, 99) < 31;
			IDLE_SEND45_RECV31: return $urandom_range(0, 99) < 45;
			default:            return 1'b0;
		endcase
	endfunction

	// offer one candidate word and hold it until it is taken
	task automatic push_word(
		input logic [wnss_pkg::CAP_W-1:0]        c,
		input logic signed [wnss_pkg::REP_W-1:0] r,
		input logic [wnss_pkg::PHASE_W-1:0]      p,
		input logic [wnss_pkg::LAT_W-1:0]        l,
		input logic                              lst
	);
		while (sender_idles()) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		capacity       <= c;
		reputation     <= r;
		node_phase     <= p;
		latency        <= l;
		last_candidate <= lst;
		do @(posedge clk); while (in_stall);
		words_sent++;
		if (lst) begin
			selections++;
		end
	endtask

	// stop offering words, let every pending result drain, then set own_phase
	task automatic write_phase(input logic [wnss_pkg::PHASE_W-1:0] v);
		in_valid <= 1'b0;
		// let the checker's count include the final word first
		@(posedge clk);
		while (expected_left != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		phase_writes++;
	endtask

	// field values weighted toward the clamp and fold boundaries,
	// with full-width draws so every bit toggles
	function automatic cand_t random_cand();
		cand_t w;
		case ($urandom_range(0, 3))
			0:       w.cap = $urandom();
			1:       w.cap = $urandom_range(990, 1010);
			default: w.cap = $urandom_range(0, 1000);
		endcase
		case ($urandom_range(0, 4))
			0:       w.rep = 16'($urandom());
			1:       w.rep = 16'($urandom_range(25590, 25610));
			2:       w.rep = 16'($urandom_range(0, 10) - 5);
			default: w.rep = 16'($urandom_range(0, 25600));
		endcase
		if ($urandom_range(0, 4) == 0) begin
			w.ph = 15'($urandom());
		end else begin
			w.ph = 15'($urandom_range(0, 23039));
		end
		case ($urandom_range(0, 3))
			0:       w.lat = 16'($urandom());
			1:       w.lat = 16'($urandom_range(1595, 1605));
			default: w.lat = 16'($urandom_range(0, 3200));
		endcase
		return w;
	endfunction

	initial begin
		cand_t                        w;
		logic [wnss_pkg::PHASE_W-1:0] ph;
		logic [wnss_pkg::PHASE_W-1:0] cur_phase;
		int                           n;
		int                           len;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---------------- directed, own_phase at its reset value
		// one candidate at the bottom of every field
		push_word(32'd0, 16'sh8000, 15'd0, 16'd0, 1'b1);
		// identical leaders: the first one keeps the selection
		push_word(32'd1000, 16'sd25600, 15'd0, 16'd1600, 1'b0);
		push_word(32'd1000, 16'sd25600, 15'd0, 16'd1600, 1'b0);
		push_word(32'd999, 16'sd25600, 15'd0, 16'd1600, 1'b1);
		// latency just over the limit, zero score at 180 degrees,
		// clamped capacity and reputation at exactly 360 degrees,
		// then every field at its top
		push_word(32'd1000, 16'sd25600, 15'd0, 16'd1601, 1'b0);
		push_word(32'd0, 16'sd0, 15'd11520, 16'd0, 1'b0);
		push_word(32'd2000, 16'sd30000, 15'd23040, 16'd1600, 1'b0);
		push_word(32'hffff_ffff, 16'sh7fff, 15'h7fff, 16'hffff, 1'b1);
		// distance one step past half a turn folds back
		push_word(32'd500, 16'sd12800, 15'd11521, 16'd100, 1'b0);
		push_word(32'd500, 16'sd12800, 15'd23039, 16'd100, 1'b1);
		// negative reputation scores like zero, so this is a tie
		push_word(32'd10, -16'sd1, 15'd100, 16'd1600, 1'b0);
		push_word(32'd10, 16'sd0, 15'd100, 16'd1600, 1'b1);
		// own_phase at its top: phase 0 is one step away, the wrap is exact
		write_phase(15'd23039);
		push_word(32'd1000, 16'sd25600, 15'd0, 16'd0, 1'b0);
		push_word(32'd1000, 16'sd25600, 15'd23039, 16'd0, 1'b1);

		// ---------------- random selections, ten phases
		for (int blk = 0; blk < 10; blk++) begin
			idle_mode = (blk < 4) ? IDLE_SEND31_RECV45 :
			            (blk < 7) ? IDLE_SEND45_RECV31 : IDLE_NONE;
			case (blk)
				0: ph = 15'd0;
				1: ph = 15'h7fff;
				2: ph = 15'd11520;
				3: ph = 15'd23039;
				default: begin
					if ($urandom_range(0, 3) == 0) begin
						ph = 15'($urandom());
					end else begin
						ph = 15'($urandom_range(0, 23039));
					end
				end
			endcase
			write_phase(ph);
			cur_phase = (ph >= 15'd23040) ? ph - 15'd23040 : ph;

			// long output hold-off while words keep coming
			if (blk == 1) begin
				hold_req = 1'b1;
			end

			// over-length selection: low scores up to the last scored slot,
			// a perfect candidate there, and perfect ones after it that
			// must be ignored
			if (blk == 4) begin
				for (int i = 0; i < 270; i++) begin
					if (i < 255) begin
						w = random_cand();
						push_word(w.cap, w.rep, w.ph, 16'($urandom_range(1601, 65535)), 1'b0);
					end else begin
						push_word(32'd1000, 16'sd25600, cur_phase, 16'd0, i == 269);
					end
				end
			end

			n = 0;
			while (n < 32) begin
				len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 12);
				for (int k = 0; k < len; k++) begin
					// now and then repeat the previous candidate to force a tie
					if (k == 0 || $urandom_range(0, 5) != 0) begin
						w = random_cand();
					end
					push_word(w.cap, w.rep, w.ph, w.lat, k == len - 1);
				end
				n += len;
			end
		end

		// ---------------- drain and verdict
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_left != 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);

		$display("covered %0d candidate words in %0d selections across %0d own_phase settings",
			words_sent, selections, phase_writes + 1);
		$display("incl. ties, clamps, phase folds, an over-length selection and an output hold-off");
		if (fail_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// watchdog
	initial begin
		#1000000;
		$display("Mismatches found");
		$finish;
	end

endmodule

[files.f]
hdl/wnss_pkg.sv
hdl/weighted_node_score_select_top.sv
hdl/wnss_checker.sv
tb/weighted_node_score_select_checker.sv
tb/tb_weighted_node_score_select_top.sv
